FILE: rtl/gsoa_pkg.sv
// Package for the goal-seek / obstacle-avoid steering core.
// Holds sequencer states, mode and register codes, angle constants and the
// CORDIC arctangent table. No dependencies.
package gsoa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = 5;

  localparam logic signed [19:0] PI_Q16     = 20'sd205887;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [17:0] ONE_Q88    = 18'sd256;
  localparam logic signed [17:0] ELEVEN_Q88 = 18'sd2816;
  localparam logic signed [17:0] TWELVE_Q88 = 18'sd3072;
  localparam logic [15:0]        LFSR_TAPS  = 16'hB400;

  typedef enum logic [1:0] {
    MODE_AVOID   = 2'd0,
    MODE_SEEK    = 2'd1,
    MODE_REACHED = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_AVOID_RADIUS       = 3'd0,
    CFG_ARRIVE_RADIUS      = 3'd1,
    CFG_SEEK_LINEAR_GAIN   = 3'd2,
    CFG_SEEK_ANGULAR_GAIN  = 3'd3,
    CFG_AVOID_LINEAR_GAIN  = 3'd4,
    CFG_AVOID_ANGULAR_GAIN = 3'd5,
    CFG_LINEAR_LIMIT       = 3'd6,
    CFG_ANGULAR_LIMIT      = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_DECIDE,
    ST_CORDIC,
    ST_BEAR,
    ST_ANGMUL,
    ST_LINMUL,
    ST_DRAW,
    ST_MOD,
    ST_WALL,
    ST_DONE
  } state_e;

  // arctan(2^-i) in radians * 65536
  function automatic logic signed [19:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [19:0] v;
    case (i)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/goal_seek_obstacle_avoid_steering_core.sv
// One request at a time: the next is accepted the cycle after the result is loaded.
// The sequencer runs the 17-step square root (once or twice), the CORDIC loop
// (CORDIC_STEPS steps) and, when a new target is drawn, the 13-step modulo per
// drawn coordinate, all sharing one 18x18 multiplier and one sequencer.
// Reset (async, active low): registers to defaults, target (8,10), LFSR 1.
module goal_seek_obstacle_avoid_steering_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] self_x_i,
  input  logic signed [15:0] self_y_i,
  input  logic signed [15:0] self_heading_i,
  input  logic signed [15:0] obstacle_x_i,
  input  logic signed [15:0] obstacle_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] linear_cmd_o,
  output logic signed [15:0] angular_cmd_o,
  output logic [1:0]         mode_o,
  output logic               wall_limited_o,
  output logic [11:0]        goal_x_o,
  output logic [11:0]        goal_y_o
);
  import gsoa_pkg::*;

  state_e state_q, state_d;

  logic [14:0] avoid_radius_q, arrive_radius_q, linear_limit_q, angular_limit_q;
  logic [11:0] seek_lin_g_q, seek_ang_g_q, avoid_lin_g_q, avoid_ang_g_q;

  logic               phase_q, zero_q, draw_q, wall_q;
  mode_e              mode_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [15:0] sx_q, sy_q, hd_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0]        acc_q, root_q;
  logic [16:0]        d_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic signed [14:0] bear_q;
  logic signed [21:0] lin_q, ang_q;
  logic [11:0]        tx_q, ty_q;
  logic [15:0]        lfsr_q;
  logic [16:0]        rem_q;

  logic               out_valid_q, out_wall_q;
  logic signed [15:0] out_lin_q, out_ang_q;
  logic [1:0]         out_mode_q;
  logic [11:0]        out_gx_q, out_gy_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod, rnd8, rnd12;
  logic signed [17:0] err, wv;
  logic               band;

  // heading error
  logic signed [17:0] yaw0, yaw_s, yaw, theta, diff, mag;
  always_comb begin
    yaw0  = (bear_q < 0) ? 18'(bear_q) + TWO_PI_Q12 : 18'(bear_q);
    yaw_s = yaw0 + PI_Q12;
    if (mode_q == MODE_AVOID) begin
      yaw = (yaw_s > TWO_PI_Q12) ? yaw_s - TWO_PI_Q12 : yaw_s;
    end else begin
      yaw = yaw0;
    end
    theta = (hd_q < 0) ? 18'(hd_q) + TWO_PI_Q12 : 18'(hd_q);
    diff  = yaw - theta;
    mag   = (diff < 0) ? -diff : diff;
    if ((yaw > theta && mag > PI_Q12) || (yaw < theta && mag < PI_Q12)) begin
      err = -mag;
    end else begin
      err = mag;
    end
  end

  // wall bands
  always_comb begin
    band = 1'b1;
    if (18'(sx_q) < ONE_Q88) begin
      wv = 18'(sx_q);
    end else if (18'(sx_q) > ELEVEN_Q88) begin
      wv = TWELVE_Q88 - 18'(sx_q);
    end else if (18'(sy_q) < ONE_Q88) begin
      wv = 18'(sy_q);
    end else if (18'(sy_q) > ELEVEN_Q88) begin
      wv = TWELVE_Q88 - 18'(sy_q);
    end else begin
      wv   = '0;
      band = 1'b0;
    end
  end

  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = 18'(dx_q);
        mul_b = 18'(dx_q);
      end
      ST_SQY: begin
        mul_a = 18'(dy_q);
        mul_b = 18'(dy_q);
      end
      ST_ANGMUL: begin
        mul_a = err;
        mul_b = $signed({6'b0, (mode_q == MODE_AVOID) ? avoid_ang_g_q : seek_ang_g_q});
      end
      ST_LINMUL: begin
        mul_a = $signed({1'b0, d_q});
        mul_b = $signed({6'b0, (mode_q == MODE_AVOID) ? avoid_lin_g_q : seek_lin_g_q});
      end
      ST_WALL: begin
        mul_a = wv;
        mul_b = $signed({6'b0, avoid_lin_g_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod  = mul_a * mul_b;
    rnd8  = (prod + 36'sd128) >>> 8;
    rnd12 = (prod + 36'sd2048) >>> 12;
  end

  // square root step
  logic [33:0] sq_bit;
  logic [34:0] sq_trial;
  logic        sq_take;
  always_comb begin
    sq_bit   = 34'(1) << (6'd32 - {cnt_q, 1'b0});
    sq_trial = {1'b0, root_q} + {1'b0, sq_bit};
    sq_take  = ({1'b0, acc_q} >= sq_trial);
  end

  // targets relative to pose, CORDIC start vector
  logic signed [16:0] tdx, tdy;
  logic signed [33:0] cxi, cyi, ysh, xsh;
  logic signed [19:0] zr;
  assign tdx = $signed({5'b0, tx_q}) - 17'(sx_q);
  assign tdy = $signed({5'b0, ty_q}) - 17'(sy_q);
  assign cxi = {{3{dx_q[16]}}, dx_q, 14'b0};
  assign cyi = {{3{dy_q[16]}}, dy_q, 14'b0};
  assign ysh = cy_q >>> cnt_q;
  assign xsh = cx_q >>> cnt_q;
  assign zr  = (cz_q + 20'sd8) >>> 4;

  // LFSR and modulo step
  logic [15:0] lfsr_n;
  logic [16:0] mod_sub, rem_n;
  assign lfsr_n  = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0);
  assign mod_sub = 17'd10 << cnt_q;
  assign rem_n   = (rem_q >= mod_sub) ? rem_q - mod_sub : rem_q;

  logic near_obst, far_goal;
  assign near_obst = (d_q < {2'b0, avoid_radius_q});
  assign far_goal  = (d_q > {2'b0, arrive_radius_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SQX;
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = ST_ROOT;
      ST_ROOT:   if (cnt_q == CNT_W'(16)) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!phase_q) begin
          state_d = near_obst ? ST_CORDIC : ST_SQX;
        end else begin
          state_d = far_goal ? ST_CORDIC : ST_DRAW;
        end
      end
      ST_CORDIC: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_BEAR;
      ST_BEAR:   state_d = ST_ANGMUL;
      ST_ANGMUL: state_d = ST_LINMUL;
      ST_LINMUL: state_d = ST_WALL;
      ST_DRAW:   state_d = ST_MOD;
      ST_MOD:    if (cnt_q == '0) state_d = draw_q ? ST_WALL : ST_DRAW;
      ST_WALL:   state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avoid_radius_q  <= 15'd384;
      arrive_radius_q <= 15'd26;
      seek_lin_g_q    <= 12'd205;
      seek_ang_g_q    <= 12'd256;
      avoid_lin_g_q   <= 12'd77;
      avoid_ang_g_q   <= 12'd384;
      linear_limit_q  <= 15'd512;
      angular_limit_q <= 15'd512;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AVOID_RADIUS:       avoid_radius_q  <= cfg_data_i;
        CFG_ARRIVE_RADIUS:      arrive_radius_q <= cfg_data_i;
        CFG_SEEK_LINEAR_GAIN:   seek_lin_g_q    <= cfg_data_i[11:0];
        CFG_SEEK_ANGULAR_GAIN:  seek_ang_g_q    <= cfg_data_i[11:0];
        CFG_AVOID_LINEAR_GAIN:  avoid_lin_g_q   <= cfg_data_i[11:0];
        CFG_AVOID_ANGULAR_GAIN: avoid_ang_g_q   <= cfg_data_i[11:0];
        CFG_LINEAR_LIMIT:       linear_limit_q  <= cfg_data_i;
        CFG_ANGULAR_LIMIT:      angular_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q   <= 12'd2048;
      ty_q   <= 12'd2560;
      lfsr_q <= 16'd1;
    end else if (state_q == ST_DRAW) begin
      lfsr_q <= lfsr_n;
    end else if (state_q == ST_MOD && cnt_q == '0) begin
      if (!draw_q) begin
        tx_q <= {rem_n[3:0] + 4'd1, 8'b0};
      end else begin
        ty_q <= {rem_n[3:0] + 4'd1, 8'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sx_q    <= self_x_i;
        sy_q    <= self_y_i;
        hd_q    <= self_heading_i;
        dx_q    <= 17'(obstacle_x_i) - 17'(self_x_i);
        dy_q    <= 17'(obstacle_y_i) - 17'(self_y_i);
        phase_q <= 1'b0;
        draw_q  <= 1'b0;
      end
      ST_SQX: acc_q <= prod[33:0];
      ST_SQY: begin
        acc_q  <= acc_q + prod[33:0];
        root_q <= '0;
        cnt_q  <= '0;
      end
      ST_ROOT: begin
        if (sq_take) begin
          acc_q  <= acc_q - sq_trial[33:0];
          root_q <= (root_q >> 1) + sq_bit;
          d_q    <= 17'((root_q >> 1) + sq_bit);
        end else begin
          root_q <= root_q >> 1;
          d_q    <= 17'(root_q >> 1);
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DECIDE: begin
        cnt_q  <= '0;
        zero_q <= (dx_q == '0) && (dy_q == '0);
        if (dx_q < 0) begin
          cx_q <= -cxi;
          cy_q <= -cyi;
          cz_q <= (dy_q >= 0) ? PI_Q16 : -PI_Q16;
        end else begin
          cx_q <= cxi;
          cy_q <= cyi;
          cz_q <= '0;
        end
        if (!phase_q) begin
          if (near_obst) begin
            mode_q <= MODE_AVOID;
          end else begin
            phase_q <= 1'b1;
            dx_q    <= tdx;
            dy_q    <= tdy;
          end
        end else if (far_goal) begin
          mode_q <= MODE_SEEK;
        end else begin
          mode_q <= MODE_REACHED;
          lin_q  <= '0;
          ang_q  <= '0;
        end
      end
      ST_CORDIC: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ysh;
          cy_q <= cy_q - xsh;
          cz_q <= cz_q + atan_lut(cnt_q);
        end else begin
          cx_q <= cx_q - ysh;
          cy_q <= cy_q + xsh;
          cz_q <= cz_q - atan_lut(cnt_q);
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_BEAR: begin
        if (zero_q) begin
          bear_q <= '0;
        end else if (zr > 20'(PI_Q12)) begin
          bear_q <= 15'(PI_Q12);
        end else if (zr < -20'(PI_Q12)) begin
          bear_q <= -15'(PI_Q12);
        end else begin
          bear_q <= zr[14:0];
        end
      end
      ST_ANGMUL: ang_q <= rnd12[21:0];
      ST_LINMUL: lin_q <= rnd8[21:0];
      ST_DRAW: begin
        rem_q <= {1'b0, lfsr_n};
        cnt_q <= CNT_W'(12);
      end
      ST_MOD: begin
        rem_q <= rem_n;
        if (cnt_q == '0) begin
          draw_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      ST_WALL: begin
        wall_q <= band;
        if (band) lin_q <= rnd8[21:0];
      end
      default: ;
    endcase
  end

  logic signed [21:0] lim_l, lim_a, lin_s, ang_s;
  assign lim_l = $signed({7'b0, linear_limit_q});
  assign lim_a = $signed({7'b0, angular_limit_q});
  assign lin_s = (lin_q > lim_l) ? lim_l : ((lin_q < -lim_l) ? -lim_l : lin_q);
  assign ang_s = (ang_q > lim_a) ? lim_a : ((ang_q < -lim_a) ? -lim_a : ang_q);

  logic out_load;
  assign out_load = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lin_q  <= lin_s[15:0];
      out_ang_q  <= ang_s[15:0];
      out_mode_q <= mode_q;
      out_wall_q <= wall_q;
      out_gx_q   <= tx_q;
      out_gy_q   <= ty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign linear_cmd_o   = out_lin_q;
  assign angular_cmd_o  = out_ang_q;
  assign mode_o         = out_mode_q;
  assign wall_limited_o = out_wall_q;
  assign goal_x_o       = out_gx_q;
  assign goal_y_o       = out_gy_q;

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SQX)
    else $error("sequencer did not start on request");
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_o != 2'd3)
    else $error("undefined mode code");
  a_goal_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> goal_x_o[7:0] == 8'd0 && goal_y_o[7:0] == 8'd0)
    else $error("target off integer grid");
  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT && cnt_q == CNT_W'(16) |=> state_q == ST_DECIDE)
    else $error("square root overran");
`endif

endmodule

FILE: tb/gsoa_steering_checker.sv
// Checker for goal_seek_obstacle_avoid_steering_core: watches the config, pose and
// command channels, predicts each command and compares it as a whole with the core's.
// Depends on gsoa_pkg.
module gsoa_steering_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] self_x_i,
  input  logic signed [15:0] self_y_i,
  input  logic signed [15:0] self_heading_i,
  input  logic signed [15:0] obstacle_x_i,
  input  logic signed [15:0] obstacle_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] linear_cmd_i,
  input  logic signed [15:0] angular_cmd_i,
  input  logic [1:0]         mode_i,
  input  logic               wall_limited_i,
  input  logic [11:0]        goal_x_i,
  input  logic [11:0]        goal_y_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output logic [11:0]        target_x_o,
  output logic [11:0]        target_y_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsoa_pkg::*;

  typedef struct packed {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [1:0]         mode;
    logic               wall;
    logic [11:0]        gx;
    logic [11:0]        gy;
  } steer_cmd_t;

  localparam longint ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2, 1};

  logic [14:0] avoid_rad, arrive_rad, lin_lim, ang_lim;
  logic [11:0] seek_lin_g, seek_ang_g, avoid_lin_g, avoid_ang_g;
  logic [11:0] tgt_x, tgt_y;
  logic [15:0] lfsr_q;
  steer_cmd_t  cmd_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = cmd_q.size();
  assign target_x_o   = tgt_x;
  assign target_y_o   = tgt_y;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt_dist(longint dx, longint dy);
    longint unsigned n, root, bitv;
    n = dx * dx + dy * dy;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, nx, r;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_Q16[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_Q16[i];
      end
      x = nx;
    end
    r = rshift_round(z, 4);
    if (r > PI_Q12) r = PI_Q12;
    if (r < -PI_Q12) r = -PI_Q12;
    return r;
  endfunction

  function automatic longint head_err(longint yaw, longint hd, bit away);
    longint theta, err;
    if (yaw < 0) yaw += TWO_PI_Q12;
    if (away) yaw = (yaw + PI_Q12 > TWO_PI_Q12) ? yaw + PI_Q12 - TWO_PI_Q12 : yaw + PI_Q12;
    theta = (hd < 0) ? hd + TWO_PI_Q12 : hd;
    err = yaw - theta;
    if (err < 0) err = -err;
    if ((yaw > theta && err > PI_Q12) || (yaw < theta && err < PI_Q12)) err = -err;
    return err;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [11:0] draw_goal();
    logic lsb;
    lsb = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (lsb) lfsr_q ^= LFSR_TAPS;
    return 12'((lfsr_q % 10 + 1) * 256);
  endfunction

  function automatic steer_cmd_t predict_steer(longint sx, longint sy, longint hd,
                                               longint ox, longint oy);
    steer_cmd_t c;
    longint lin, ang, d, g;
    lin = 0;
    ang = 0;
    g = avoid_lin_g;
    c.wall = 1'b1;
    d = isqrt_dist(ox - sx, oy - sy);
    if (d < avoid_rad) begin
      c.mode = MODE_AVOID;
      lin = rshift_round(d * g, 8);
      ang = rshift_round(head_err(bearing(ox - sx, oy - sy), hd, 1'b1) * avoid_ang_g, 12);
    end else begin
      d = isqrt_dist(tgt_x - sx, tgt_y - sy);
      if (d > arrive_rad) begin
        c.mode = MODE_SEEK;
        lin = rshift_round(d * seek_lin_g, 8);
        ang = rshift_round(head_err(bearing(tgt_x - sx, tgt_y - sy), hd, 1'b0) * seek_ang_g,
                           12);
      end else begin
        c.mode = MODE_REACHED;
        tgt_x = draw_goal();
        tgt_y = draw_goal();
      end
    end
    if (sx < ONE_Q88) lin = rshift_round(sx * g, 8);
    else if (sx > ELEVEN_Q88) lin = rshift_round((TWELVE_Q88 - sx) * g, 8);
    else if (sy < ONE_Q88) lin = rshift_round(sy * g, 8);
    else if (sy > ELEVEN_Q88) lin = rshift_round((TWELVE_Q88 - sy) * g, 8);
    else c.wall = 1'b0;
    c.lin = 16'(clamp(lin, lin_lim));
    c.ang = 16'(clamp(ang, ang_lim));
    c.gx  = tgt_x;
    c.gy  = tgt_y;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t exp_c, got_c;
    if (!rst_ni) begin
      avoid_rad   = 384;
      arrive_rad  = 26;
      seek_lin_g  = 205;
      seek_ang_g  = 256;
      avoid_lin_g = 77;
      avoid_ang_g = 384;
      lin_lim     = 512;
      ang_lim     = 512;
      tgt_x       = 2048;
      tgt_y       = 2560;
      lfsr_q      = 1;
      fails       = 0;
      cmd_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_AVOID_RADIUS:       avoid_rad   = cfg_data_i;
          CFG_ARRIVE_RADIUS:      arrive_rad  = cfg_data_i;
          CFG_SEEK_LINEAR_GAIN:   seek_lin_g  = cfg_data_i[11:0];
          CFG_SEEK_ANGULAR_GAIN:  seek_ang_g  = cfg_data_i[11:0];
          CFG_AVOID_LINEAR_GAIN:  avoid_lin_g = cfg_data_i[11:0];
          CFG_AVOID_ANGULAR_GAIN: avoid_ang_g = cfg_data_i[11:0];
          CFG_LINEAR_LIMIT:       lin_lim     = cfg_data_i;
          CFG_ANGULAR_LIMIT:      ang_lim     = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_c = '{linear_cmd_i, angular_cmd_i, mode_i, wall_limited_i, goal_x_i, goal_y_i};
        if (cmd_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected command: %p", got_c);
        end else begin
          exp_c = cmd_q.pop_front();
          if (got_c !== exp_c) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, got %p", exp_c, got_c);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        cmd_q.push_back(predict_steer(self_x_i, self_y_i, self_heading_i,
                                      obstacle_x_i, obstacle_y_i));
    end
  end

endmodule

FILE: tb/tb_goal_seek_obstacle_avoid_steering_core.sv
// Top of the steering core testbench: clock, reset, configuration and pose
// requests under several idling phases, and the verdict.
// Depends on gsoa_pkg, the core and gsoa_steering_checker.
module tb_goal_seek_obstacle_avoid_steering_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gsoa_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  logic               clk_i, rst_ni;
  logic               cfg_valid_i, cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [14:0]        cfg_data_i;
  logic               in_valid_i, in_stall_o;
  logic signed [15:0] self_x_i, self_y_i, self_heading_i, obstacle_x_i, obstacle_y_i;
  logic               out_valid_o, out_stall_i;
  logic signed [15:0] linear_cmd_o, angular_cmd_o;
  logic [1:0]         mode_o;
  logic               wall_limited_o;
  logic [11:0]        goal_x_o, goal_y_o;
  int                 fail_count, pending;
  logic [11:0]        tgt_x, tgt_y;
  int                 send_idle_pct, stall_pct, arrive_now, cycles;

  goal_seek_obstacle_avoid_steering_core DUT (.*);

  gsoa_steering_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .self_x_i, .self_y_i, .self_heading_i,
    .obstacle_x_i, .obstacle_y_i, .out_valid_i(out_valid_o), .out_stall_i,
    .linear_cmd_i(linear_cmd_o), .angular_cmd_i(angular_cmd_o), .mode_i(mode_o),
    .wall_limited_i(wall_limited_o), .goal_x_i(goal_x_o), .goal_y_i(goal_y_o),
    .fail_count_o(fail_count), .pending_o(pending), .target_x_o(tgt_x), .target_y_o(tgt_y)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("goal_seek_obstacle_avoid_steering_core test failed");
      $finish;
    end
  end

  task automatic send_pose(int sx, int sy, int hd, int ox, int oy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    self_x_i       <= 16'(sx);
    self_y_i       <= 16'(sy);
    self_heading_i <= 16'(hd);
    obstacle_x_i   <= 16'(ox);
    obstacle_y_i   <= 16'(oy);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // leaves the write valid high; the caller drops it after the last write
  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 15'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ARRIVE_RADIUS) arrive_now = val;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // mostly well-formed poses inside the arena, with arrivals, near obstacles and walls
  task automatic random_pose();
    int sx, sy, hd, ox, oy, r, kind;
    kind = $urandom_range(0, 9);
    sx = $urandom_range(0, 3072);
    sy = $urandom_range(0, 3072);
    hd = $urandom_range(0, 51472) - 25736;
    ox = sx + $urandom_range(0, 4000) - 2000;
    oy = sy + $urandom_range(0, 4000) - 2000;
    if (kind < 3) begin
      r  = (arrive_now > 400) ? 200 : arrive_now / 2;
      sx = tgt_x + $urandom_range(0, 2 * r) - r;
      sy = tgt_y + $urandom_range(0, 2 * r) - r;
      ox = sx + 9000;
      oy = sy - 9000;
    end else if (kind < 5) begin
      ox = sx + $urandom_range(0, 800) - 400;
      oy = sy + $urandom_range(0, 800) - 400;
    end else if (kind == 5) begin
      sx = $urandom_range(0, 65535);
      sy = $urandom_range(0, 65535);
      hd = $urandom_range(0, 65535);
      ox = $urandom_range(0, 65535);
      oy = $urandom_range(0, 65535);
    end
    send_pose(sx, sy, hd, ox, oy);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_AVOID_RADIUS;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    self_x_i <= '0;
    self_y_i <= '0;
    self_heading_i <= '0;
    obstacle_x_i <= '0;
    obstacle_y_i <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    arrive_now = 26;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(-32768, -32768, -32768, 32767, 32767);
    send_pose(32767, 32767, 32767, -32768, -32768);
    send_pose(1000, 1000, 0, 1000, 1000);            // obstacle on top of robot
    send_pose(1500, 1500, 12868, 1300, 1500);        // obstacle on negative x axis
    send_pose(1500, 1500, -12868, 1700, 1500);
    send_pose(1500, 1500, 25736, 9000, 9000);
    send_pose(1500, 1500, -25736, 9000, 9000);
    send_pose(100, 1500, 0, 9000, 9000);             // wall bands
    send_pose(3000, 1500, 0, 9000, 9000);
    send_pose(1500, 100, 0, 9000, 9000);
    send_pose(1500, 3000, 0, 9000, 9000);
    send_pose(-2000, 1500, 0, 9000, 9000);
    send_pose(2048, 2560, 4000, 9000, 9000);         // exactly on the target
    send_pose(2048 - 26, 2560, 0, 9000, 9000);
    send_pose(tgt_x + 26, tgt_y, 0, 9000, 9000);
    send_pose(1500, 1500, 0, 1500 + 383, 1500);      // avoid radius edge
    send_pose(1500, 1500, 0, 1500 + 384, 1500);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) begin
        for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), 32767);
      end else if (ph == 2) begin
        for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), 0);
      end else if (ph == 5) begin
        write_reg(CFG_AVOID_RADIUS, 384);
        write_reg(CFG_ARRIVE_RADIUS, 26);
        write_reg(CFG_SEEK_LINEAR_GAIN, 4095);
        write_reg(CFG_SEEK_ANGULAR_GAIN, 4095);
        write_reg(CFG_AVOID_LINEAR_GAIN, 4095);
        write_reg(CFG_AVOID_ANGULAR_GAIN, 4095);
        write_reg(CFG_LINEAR_LIMIT, 32767);
        write_reg(CFG_ANGULAR_LIMIT, 32767);
      end else if (ph > 2) begin
        write_reg(CFG_AVOID_RADIUS, $urandom_range(0, 1200));
        write_reg(CFG_ARRIVE_RADIUS, $urandom_range(0, 600));
        for (int i = 2; i < 6; i++) write_reg(cfg_idx_e'(i), $urandom_range(0, 4095));
        write_reg(CFG_LINEAR_LIMIT, $urandom_range(0, 32767));
        write_reg(CFG_ANGULAR_LIMIT, $urandom_range(0, 32767));
      end
      cfg_valid_i <= 1'b0;
      for (int k = 0; k < 90; k++) begin
        case ((k / 20 + ph) % 5)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 50; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 50; end
          3: begin send_idle_pct = 34; stall_pct = 34; end
          default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
        random_pose();
      end
      drain();
    end

    stall_pct = 0;
    if (fail_count == 0) begin
      $display("goal_seek_obstacle_avoid_steering_core test passed");
    end else begin
      $display("goal_seek_obstacle_avoid_steering_core test failed");
    end
    $finish;
  end

endmodule
